// ===== rtl/core/u8u16_pkg.sv =====
package u8u16_pkg;

    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;

    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] PLANE1_BASE  = 21'h010000;
    localparam logic [20:0] SURR_FIRST   = 21'h00D800;
    localparam logic [20:0] SURR_LAST    = 21'h00DFFF;
    localparam logic [20:0] MIN_TWO_BYTE = 21'h000080;
    localparam logic [20:0] MIN_THREE    = 21'h000800;

    localparam logic [2:0]  LEN_NONE  = 3'd0;
    localparam logic [2:0]  LEN_TWO   = 3'd2;
    localparam logic [2:0]  LEN_THREE = 3'd3;
    localparam logic [2:0]  LEN_FOUR  = 3'd4;

    // Units still to be sent for one accepted byte: replacement units first,
    // then up to two ordinary units.
    typedef struct packed {
        logic [2:0]  repl_cnt;
        logic [1:0]  tail_cnt;
        logic [15:0] tail0;
        logic [15:0] tail1;
        logic        tail0_bad;
        logic        string_end;
    } job_t;

    function automatic logic [20:0] min_for_length(input logic [2:0] len);
        logic [20:0] result;
        begin
            if (len == LEN_TWO) begin
                result = MIN_TWO_BYTE;
            end
            else if (len == LEN_THREE) begin
                result = MIN_THREE;
            end
            else begin
                result = PLANE1_BASE;
            end
            return result;
        end
    endfunction

endpackage

// ===== rtl/core/utf8_to_utf16_transcoder.sv =====
// UTF-8 to UTF-16 transcoder.
// Input channel: byte_in and string_end with byte_valid / byte_stall; one
// request is one UTF-8 byte, string_end marking the final byte of a string.
// Output channel: utf16_unit, bad_input, run_last and string_done with
// unit_valid / unit_stall; one request is one UTF-16 code unit.
// A byte is decoded in the cycle it is accepted and its units appear in the
// result register from the next cycle on, one unit per cycle while the
// receiver does not stall. A byte gives k units (k from 0 to 4), and
// without stalls the sustained rate is one byte per cycle for text of one
// unit per byte; a byte of several units holds the result register until
// its last unit is taken. Bytes that yield nothing (lead and middle
// continuation bytes) pass without occupying the result register.
// While the receiver stalls, the current unit holds steady. byte_stall is
// high while the result register holds units of a byte; it falls again in
// the cycle the last of them is taken, so the next byte enters at once.
// Reset clears any partly gathered sequence and empties the result register.
module utf8_to_utf16_transcoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  byte_in,
    input  logic        string_end,
    input  logic        byte_valid,
    output logic        byte_stall,
    output logic [15:0] utf16_unit,
    output logic        bad_input,
    output logic        run_last,
    output logic        string_done,
    output logic        unit_valid,
    input  logic        unit_stall
);

    logic [20:0]       pv_reg;
    logic [20:0]       pv_next;
    logic [2:0]        len_reg;
    logic [2:0]        len_next;
    logic [2:0]        held_reg;
    logic [2:0]        held_next;

    u8u16_pkg::job_t   job_reg;
    u8u16_pkg::job_t   job_next;
    logic              job_valid_reg;
    logic              job_valid_next;
    u8u16_pkg::job_t   dec;

    logic              cont;
    logic              fresh;
    logic [2:0]        held_inc;
    logic [20:0]       pv_shift;
    logic [20:0]       plane_off;
    logic              cp_bad;
    logic [2:0]        lead_len;
    logic [20:0]       lead_bits;
    logic [2:0]        dec_count;
    logic [2:0]        remaining;
    logic              is_last;
    logic              out_take;
    logic              slot_free;
    logic              accept;

    assign cont      = (byte_in[7:6] == 2'b10);
    assign held_inc  = held_reg + 3'd1;
    assign pv_shift  = {pv_reg[14:0], byte_in[5:0]};
    assign plane_off = pv_shift - u8u16_pkg::PLANE1_BASE;
    assign cp_bad    = ((pv_shift >= u8u16_pkg::SURR_FIRST) && (pv_shift <= u8u16_pkg::SURR_LAST))
                       || (pv_shift < u8u16_pkg::min_for_length(len_reg))
                       || (pv_shift > u8u16_pkg::CP_MAX);

    always_comb
    begin
        if (byte_in[7:5] == 3'b110) begin
            lead_len  = u8u16_pkg::LEN_TWO;
            lead_bits = {16'd0, byte_in[4:0]};
        end
        else if (byte_in[7:4] == 4'b1110) begin
            lead_len  = u8u16_pkg::LEN_THREE;
            lead_bits = {17'd0, byte_in[3:0]};
        end
        else if (byte_in[7:3] == 5'b11110) begin
            lead_len  = u8u16_pkg::LEN_FOUR;
            lead_bits = {18'd0, byte_in[2:0]};
        end
        else begin
            lead_len  = u8u16_pkg::LEN_NONE;
            lead_bits = '0;
        end
    end

    always_comb
    begin
        pv_next        = pv_reg;
        len_next       = len_reg;
        held_next      = held_reg;
        dec            = '0;
        dec.string_end = string_end;
        fresh          = 1'b1;

        if (len_reg != u8u16_pkg::LEN_NONE) begin
            if (cont) begin
                fresh = 1'b0;
                if (held_inc >= len_reg) begin
                    if (cp_bad) begin
                        dec.repl_cnt = held_inc;
                    end
                    else if (pv_shift < u8u16_pkg::PLANE1_BASE) begin
                        dec.tail_cnt = 2'd1;
                        dec.tail0    = pv_shift[15:0];
                    end
                    else begin
                        dec.tail_cnt = 2'd2;
                        dec.tail0    = u8u16_pkg::SURR_HI_BASE | {6'd0, plane_off[19:10]};
                        dec.tail1    = u8u16_pkg::SURR_LO_BASE | {6'd0, plane_off[9:0]};
                    end
                    pv_next   = '0;
                    len_next  = u8u16_pkg::LEN_NONE;
                    held_next = '0;
                end
                else if (string_end) begin
                    dec.repl_cnt = held_inc;
                    pv_next      = '0;
                    len_next     = u8u16_pkg::LEN_NONE;
                    held_next    = '0;
                end
                else begin
                    pv_next   = pv_shift;
                    held_next = held_inc;
                end
            end
            else begin
                // The sequence is broken: every byte held is replaced and the
                // new byte is decoded from scratch below.
                dec.repl_cnt = held_reg;
                pv_next      = '0;
                len_next     = u8u16_pkg::LEN_NONE;
                held_next    = '0;
            end
        end

        if (fresh) begin
            if (!byte_in[7]) begin
                dec.tail_cnt = 2'd1;
                dec.tail0    = {8'd0, byte_in};
            end
            else if (lead_len == u8u16_pkg::LEN_NONE) begin
                dec.tail_cnt  = 2'd1;
                dec.tail0     = u8u16_pkg::REPL_UNIT;
                dec.tail0_bad = 1'b1;
            end
            else if (string_end) begin
                dec.tail_cnt  = 2'd1;
                dec.tail0     = u8u16_pkg::REPL_UNIT;
                dec.tail0_bad = 1'b1;
            end
            else begin
                pv_next   = lead_bits;
                len_next  = lead_len;
                held_next = 3'd1;
            end
        end
    end

    assign dec_count = dec.repl_cnt + {1'b0, dec.tail_cnt};
    assign remaining = job_reg.repl_cnt + {1'b0, job_reg.tail_cnt};
    assign is_last   = (remaining == 3'd1);
    assign out_take  = job_valid_reg && !unit_stall;
    assign slot_free = !job_valid_reg || (out_take && is_last);
    assign accept    = byte_valid && slot_free;

    assign byte_stall  = !slot_free;
    assign unit_valid  = job_valid_reg;
    assign utf16_unit  = (job_reg.repl_cnt != 3'd0) ? u8u16_pkg::REPL_UNIT : job_reg.tail0;
    assign bad_input   = (job_reg.repl_cnt != 3'd0) || job_reg.tail0_bad;
    assign run_last    = is_last;
    assign string_done = is_last && job_reg.string_end;

    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        if (accept && (dec_count != 3'd0)) begin
            job_next       = dec;
            job_valid_next = 1'b1;
        end
        else if (out_take) begin
            if (is_last) begin
                job_valid_next = 1'b0;
            end
            else if (job_reg.repl_cnt != 3'd0) begin
                job_next.repl_cnt = job_reg.repl_cnt - 3'd1;
            end
            else begin
                job_next.tail0     = job_reg.tail1;
                job_next.tail0_bad = 1'b0;
                job_next.tail_cnt  = job_reg.tail_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pv_reg        <= '0;
            len_reg       <= u8u16_pkg::LEN_NONE;
            held_reg      <= '0;
            job_valid_reg <= 1'b0;
            job_reg       <= '0;
        end
        else begin
            if (accept) begin
                pv_reg   <= pv_next;
                len_reg  <= len_next;
                held_reg <= held_next;
            end
            job_valid_reg <= job_valid_next;
            job_reg       <= job_next;
        end
    end

    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> unit_valid)
        else $error("input stalled with no unit waiting");

    a_bad_is_replacement: assert property (@(posedge clk) disable iff (!rst_n)
        (unit_valid && bad_input) |-> (utf16_unit == u8u16_pkg::REPL_UNIT))
        else $error("bad_input set on a unit other than the replacement");

    a_held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != u8u16_pkg::LEN_NONE) |-> ((held_reg != 3'd0) && (held_reg < len_reg)))
        else $error("held byte count outside the pending sequence");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (unit_valid && !unit_stall && !run_last) |=> unit_valid)
        else $error("units of one byte lost before its last unit");

    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid |-> (remaining != 3'd0) && (remaining <= 3'd4))
        else $error("result register holds an impossible unit count");

endmodule
